// ===== hdl/i2r_pkg.sv =====
// ----------------------------------------------------------------------------
// i2r_pkg: shared types, constants and letter tables
// Widths, queue entry layout, state encodings and the per-digit letter
// functions used by the front, queue and back of the Roman numeral encoder.
// ----------------------------------------------------------------------------
package i2r_pkg;

    localparam int NUM_W         = 13;   // width of the binary input value
    localparam int DIG_W         = 4;    // one BCD digit
    localparam int NUM_DIGITS    = 4;    // thousands, hundreds, tens, units
    localparam int BCD_W         = NUM_DIGITS * DIG_W;
    localparam int MAX_VALUE_DEF = 5000;
    localparam int MAX_LETTERS   = 19;   // letters kept per number
    localparam int LCNT_W        = $clog2(MAX_LETTERS);
    localparam int QUEUE_DEPTH   = 2;
    localparam int LETTER_W      = 8;
    localparam int POS_W         = 3;    // position inside one digit group
    localparam int GRP_W         = $clog2(NUM_DIGITS);
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SUBTRACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_CASE  = 2'd1;

    // Digit groups, most significant first
    localparam logic [GRP_W-1:0] GRP_THOUSANDS = 2'd0;
    localparam logic [GRP_W-1:0] GRP_HUNDREDS  = 2'd1;
    localparam logic [GRP_W-1:0] GRP_TENS      = 2'd2;
    localparam logic [GRP_W-1:0] GRP_UNITS     = 2'd3;

    // Upper-case ASCII letters and the case bit
    localparam logic [LETTER_W-1:0] CHAR_M   = 8'h4D;
    localparam logic [LETTER_W-1:0] CHAR_D   = 8'h44;
    localparam logic [LETTER_W-1:0] CHAR_C   = 8'h43;
    localparam logic [LETTER_W-1:0] CHAR_L   = 8'h4C;
    localparam logic [LETTER_W-1:0] CHAR_X   = 8'h58;
    localparam logic [LETTER_W-1:0] CHAR_V   = 8'h56;
    localparam logic [LETTER_W-1:0] CHAR_I   = 8'h49;
    localparam logic [LETTER_W-1:0] CASE_BIT = 8'h20;

    // One request as it travels from front to back
    typedef struct packed {
        logic                                bad;
        logic                                subtractive;
        logic                                lower;
        logic [NUM_DIGITS-1:0][DIG_W-1:0]    digit;   // index 0 is thousands
    } item_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CONV,
        F_PUSH
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } back_state_t;

    // Number of letters one digit group produces
    function automatic logic [DIG_W-1:0] group_count(
        input logic [GRP_W-1:0] grp,
        input logic [DIG_W-1:0] d,
        input logic             sub
    );
        logic [DIG_W-1:0] r;
        if (grp == GRP_THOUSANDS) begin
            r = d;
        end else if (sub && (d == 4'd9 || d == 4'd4)) begin
            r = 4'd2;
        end else if (d >= 4'd5) begin
            r = d - 4'd4;
        end else begin
            r = d;
        end
        return r;
    endfunction

    // Upper-case letter at a given position of one digit group
    function automatic logic [LETTER_W-1:0] group_letter(
        input logic [GRP_W-1:0] grp,
        input logic [DIG_W-1:0] d,
        input logic             sub,
        input logic [POS_W-1:0] pos
    );
        logic [LETTER_W-1:0] one_c;
        logic [LETTER_W-1:0] five_c;
        logic [LETTER_W-1:0] ten_c;
        logic [LETTER_W-1:0] r;
        logic                first;
        case (grp)
            GRP_THOUSANDS:
            begin
                one_c = CHAR_M; five_c = CHAR_M; ten_c = CHAR_M;
            end
            GRP_HUNDREDS:
            begin
                one_c = CHAR_C; five_c = CHAR_D; ten_c = CHAR_M;
            end
            GRP_TENS:
            begin
                one_c = CHAR_X; five_c = CHAR_L; ten_c = CHAR_C;
            end
            default:
            begin
                one_c = CHAR_I; five_c = CHAR_V; ten_c = CHAR_X;
            end
        endcase
        first = (pos == '0);
        if (grp == GRP_THOUSANDS) begin
            r = one_c;
        end else if (sub && d == 4'd9) begin
            r = first ? one_c : ten_c;
        end else if (sub && d == 4'd4) begin
            r = first ? one_c : five_c;
        end else if (d >= 4'd5) begin
            r = first ? five_c : one_c;
        end else begin
            r = one_c;
        end
        return r;
    endfunction

endpackage

// ===== hdl/integer_to_roman_numeral.sv =====
// Order of events: conversion, queue hand-off, then the letters, with empty
//   digit groups skipped; an out-of-range value skips conversion and gives
//   its single error result.
// Throughput: one letter a cycle while the sequencer walks a nonempty digit
//   group; empty groups and the step between numbers give none; no stalls out.
// Reset (rst_n low) empties the queue, idles both halves, clears both registers.
// ----------------------------------------------------------------------------
// integer_to_roman_numeral: binary to Roman numeral letter stream
// Front converts and checks each value, a two-entry queue decouples it from
// the back, which emits one ASCII letter per strobe (a zero for an error).
// ----------------------------------------------------------------------------
module integer_to_roman_numeral #(
    parameter int unsigned MAX_VALUE = i2r_pkg::MAX_VALUE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [i2r_pkg::NUM_W-1:0]           number_in,
    output logic                                strobe,
    output logic [i2r_pkg::LETTER_W-1:0]        letter,
    output logic                                last_letter,
    output logic                                bad_value,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [i2r_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [i2r_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic           subtractive_form_reg, subtractive_form_next;
    logic           lower_case_reg, lower_case_next;
    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    i2r_pkg::item_t push_item;
    i2r_pkg::item_t head_item;

    assign cfg_ready = 1'b1;

    // Decode register writes, keep bit 0 only
    always_comb
    begin
        subtractive_form_next = subtractive_form_reg;
        lower_case_next       = lower_case_reg;
        if (cfg_valid) begin
            case (cfg_index)
                i2r_pkg::REG_SUBTRACTIVE: subtractive_form_next = cfg_data[0];
                i2r_pkg::REG_LOWER_CASE:  lower_case_next       = cfg_data[0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            subtractive_form_reg <= 1'b0;
            lower_case_reg       <= 1'b0;
        end else begin
            subtractive_form_reg <= subtractive_form_next;
            lower_case_reg       <= lower_case_next;
        end
    end

    i2r_front #(
        .MAX_VALUE        (MAX_VALUE)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .number_in        (number_in),
        .subtractive_form (subtractive_form_reg),
        .lower_case       (lower_case_reg),
        .busy             (busy),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_item           (push_item)
    );

    i2r_queue u_queue (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (q_push),
        .push_item        (push_item),
        .full             (q_full),
        .pop              (q_pop),
        .empty            (q_empty),
        .head_item        (head_item)
    );

    i2r_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_head           (head_item),
        .q_pop            (q_pop),
        .strobe           (strobe),
        .letter           (letter),
        .last_letter      (last_letter),
        .bad_value        (bad_value)
    );

endmodule

// ===== hdl/i2r_front.sv =====
// ----------------------------------------------------------------------------
// i2r_front: request intake and decimal conversion
// Takes one value, flags it when out of range, else converts it to four BCD
// digits by shift-and-add-3 (one bit a cycle) and pushes it to the queue.
// ----------------------------------------------------------------------------
module i2r_front #(
    parameter int unsigned MAX_VALUE = i2r_pkg::MAX_VALUE_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [i2r_pkg::NUM_W-1:0]   number_in,
    input  logic                        subtractive_form,
    input  logic                        lower_case,
    output logic                        busy,
    input  logic                        q_full,
    output logic                        q_push,
    output i2r_pkg::item_t              q_item
);

    localparam int NW    = i2r_pkg::NUM_W;
    localparam int BW    = i2r_pkg::BCD_W;
    localparam int DW    = i2r_pkg::DIG_W;
    localparam int CNT_W = $clog2(NW);
    localparam logic [NW-1:0]    MAX_N    = NW'(MAX_VALUE);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(NW - 1);

    i2r_pkg::front_state_t state_reg, state_next;
    logic [BW+NW-1:0]      shift_reg, shift_next;
    logic [CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic                  bad_reg, bad_next;
    logic                  sub_reg, sub_next;
    logic                  low_reg, low_next;
    logic                  accept;
    logic                  in_bad;
    logic [BW-1:0]         adjusted;
    logic [BW+NW-1:0]      stepped;

    assign accept = start && (state_reg == i2r_pkg::F_IDLE);
    assign in_bad = (number_in == '0) || (number_in > MAX_N);

    // Add 3 to every digit of 5 or more, then shift in the next bit
    always_comb
    begin
        for (int k = 0; k < i2r_pkg::NUM_DIGITS; k++)
        begin
            if (shift_reg[NW + DW*k +: DW] >= 4'd5) begin
                adjusted[DW*k +: DW] = shift_reg[NW + DW*k +: DW] + 4'd3;
            end else begin
                adjusted[DW*k +: DW] = shift_reg[NW + DW*k +: DW];
            end
        end
        stepped = {adjusted, shift_reg[NW-1:0]} << 1;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            i2r_pkg::F_IDLE:
            begin
                if (start) begin
                    state_next = in_bad ? i2r_pkg::F_PUSH : i2r_pkg::F_CONV;
                end
            end
            i2r_pkg::F_CONV:
            begin
                if (bit_cnt_reg == LAST_BIT) begin
                    state_next = i2r_pkg::F_PUSH;
                end
            end
            i2r_pkg::F_PUSH:
            begin
                if (!q_full) begin
                    state_next = i2r_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = i2r_pkg::F_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        shift_next   = shift_reg;
        bit_cnt_next = bit_cnt_reg;
        bad_next     = bad_reg;
        sub_next     = sub_reg;
        low_next     = low_reg;
        if (accept) begin
            shift_next   = in_bad ? '0 : {{BW{1'b0}}, number_in};
            bit_cnt_next = '0;
            bad_next     = in_bad;
            sub_next     = subtractive_form;
            low_next     = lower_case;
        end else if (state_reg == i2r_pkg::F_CONV) begin
            shift_next   = stepped;
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end
        busy                = (state_reg != i2r_pkg::F_IDLE);
        q_push              = (state_reg == i2r_pkg::F_PUSH) && !q_full;
        q_item.bad          = bad_reg;
        q_item.subtractive  = sub_reg;
        q_item.lower        = low_reg;
        q_item.digit[0]     = shift_reg[NW + 3*DW +: DW];
        q_item.digit[1]     = shift_reg[NW + 2*DW +: DW];
        q_item.digit[2]     = shift_reg[NW + DW +: DW];
        q_item.digit[3]     = shift_reg[NW +: DW];
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= i2r_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold conversion payload
    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        bit_cnt_reg <= bit_cnt_next;
        bad_reg     <= bad_next;
        sub_reg     <= sub_next;
        low_reg     <= low_next;
    end

    // A taken request always makes the front busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("front not busy after taking a request");

    // Rejected values never enter the conversion loop
    a_bad_skips_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == i2r_pkg::F_CONV) |-> !bad_reg)
        else $error("rejected value under conversion");

    // A push frees the front for the next request
    a_push_frees: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> !busy)
        else $error("front still busy after pushing a request");

endmodule

// ===== hdl/i2r_queue.sv =====
// ----------------------------------------------------------------------------
// i2r_queue: short request queue between front and back
// A small circular buffer of converted requests so that conversion of the
// next value overlaps letter output of the current one.
// ----------------------------------------------------------------------------
module i2r_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  i2r_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output i2r_pkg::item_t  head_item
);

    localparam int DEPTH = i2r_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    i2r_pkg::item_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign empty     = (count_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed requests
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue occupancy beyond depth");

endmodule

// ===== hdl/i2r_back.sv =====
// ----------------------------------------------------------------------------
// i2r_back: letter sequencer
// Walks the digit groups of one request, issues one numeral letter a cycle
// in nonempty groups and marks the last; rejects give a single error result.
// ----------------------------------------------------------------------------
module i2r_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  i2r_pkg::item_t                  q_head,
    output logic                            q_pop,
    output logic                            strobe,
    output logic [i2r_pkg::LETTER_W-1:0]    letter,
    output logic                            last_letter,
    output logic                            bad_value
);

    localparam int GW = i2r_pkg::GRP_W;
    localparam int PW = i2r_pkg::POS_W;
    localparam int LW = i2r_pkg::LCNT_W;
    localparam logic [LW-1:0] LCNT_CAP = LW'(i2r_pkg::MAX_LETTERS - 1);

    i2r_pkg::back_state_t           state_reg, state_next;
    i2r_pkg::item_t                 item_reg, item_next;
    logic [GW-1:0]                  grp_reg, grp_next;
    logic [PW-1:0]                  pos_reg, pos_next;
    logic [LW-1:0]                  lcnt_reg, lcnt_next;
    logic                           strobe_reg, strobe_next;
    logic [i2r_pkg::LETTER_W-1:0]   letter_reg, letter_next;
    logic                           last_reg, last_next;
    logic                           bad_reg, bad_next;

    logic [i2r_pkg::DIG_W-1:0]      cur_digit;
    logic [i2r_pkg::DIG_W-1:0]      grp_cnt;
    logic                           rest_zero;
    logic                           grp_end;
    logic                           is_last;
    logic                           emit;
    logic                           done;
    logic [i2r_pkg::LETTER_W-1:0]   cur_letter;

    // Decode the current group and position
    always_comb
    begin
        cur_digit = item_reg.digit[grp_reg];
        grp_cnt   = i2r_pkg::group_count(grp_reg, cur_digit, item_reg.subtractive);
        rest_zero = 1'b1;
        for (int k = 0; k < i2r_pkg::NUM_DIGITS; k++)
        begin
            if ((GW'(k) > grp_reg) && (item_reg.digit[k] != '0)) begin
                rest_zero = 1'b0;
            end
        end
        grp_end    = ({1'b0, pos_reg} == grp_cnt - 1'b1);
        is_last    = (grp_end && rest_zero) || (lcnt_reg == LCNT_CAP);
        cur_letter = i2r_pkg::group_letter(grp_reg, cur_digit,
                                           item_reg.subtractive, pos_reg)
                     | (item_reg.lower ? i2r_pkg::CASE_BIT : '0);
        emit       = (state_reg == i2r_pkg::B_RUN) && (item_reg.bad || grp_cnt != '0);
        done       = (state_reg == i2r_pkg::B_RUN) &&
                     (item_reg.bad || (grp_cnt != '0 && is_last) ||
                      (grp_cnt == '0 && grp_reg == i2r_pkg::GRP_UNITS));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            i2r_pkg::B_IDLE:
            begin
                if (!q_empty) begin
                    state_next = i2r_pkg::B_RUN;
                end
            end
            i2r_pkg::B_RUN:
            begin
                if (done) begin
                    state_next = i2r_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = i2r_pkg::B_IDLE;
            end
        endcase
    end

    // Counters, queue pop and result register
    always_comb
    begin
        q_pop       = (state_reg == i2r_pkg::B_IDLE) && !q_empty;
        item_next   = item_reg;
        grp_next    = grp_reg;
        pos_next    = pos_reg;
        lcnt_next   = lcnt_reg;
        if (q_pop) begin
            item_next = q_head;
            grp_next  = '0;
            pos_next  = '0;
            lcnt_next = '0;
        end else if (state_reg == i2r_pkg::B_RUN) begin
            if (grp_cnt == '0) begin
                grp_next = grp_reg + 1'b1;
                pos_next = '0;
            end else if (grp_end) begin
                grp_next  = grp_reg + 1'b1;
                pos_next  = '0;
                lcnt_next = lcnt_reg + 1'b1;
            end else begin
                pos_next  = pos_reg + 1'b1;
                lcnt_next = lcnt_reg + 1'b1;
            end
        end
        strobe_next = emit;
        letter_next = item_reg.bad ? '0 : cur_letter;
        last_next   = item_reg.bad || is_last;
        bad_next    = item_reg.bad;
    end

    assign strobe      = strobe_reg;
    assign letter      = letter_reg;
    assign last_letter = last_reg;
    assign bad_value   = bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= i2r_pkg::B_IDLE;
            strobe_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        grp_reg    <= grp_next;
        pos_reg    <= pos_next;
        lcnt_reg   <= lcnt_next;
        letter_reg <= letter_next;
        last_reg   <= last_next;
        bad_reg    <= bad_next;
    end

    // An error result is a single, final, zero letter
    a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && bad_value |-> last_letter && (letter == '0))
        else $error("malformed error result");

    // Letter count never runs past the cap
    a_letter_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == i2r_pkg::B_RUN) |-> (lcnt_reg <= LCNT_CAP))
        else $error("letter count beyond cap");

    // A final letter ends the request
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        emit && last_next |=> (state_reg == i2r_pkg::B_IDLE))
        else $error("sequencer kept running after final letter");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: Roman numeral encoder letter stream check
// Sends binary values through the command port, predicts the letter stream
// of each accepted request under the current form and case registers, and
// compares every strobed letter against the oldest letter still due.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned MAX_VALUE_TB   = i2r_pkg::MAX_VALUE_DEF;
    localparam int unsigned TOP_INPUT      = (1 << i2r_pkg::NUM_W) - 1;
    localparam int          SETTLE_CYCLES  = 24;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_BLOCK   = 59;

    // Register indexes with no register behind them
    localparam logic [i2r_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [i2r_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef logic [i2r_pkg::NUM_W-1:0] number_t;

    typedef struct packed {
        logic [i2r_pkg::LETTER_W-1:0] code;
        logic                         last;
        logic                         bad;
    } letter_rec_t;

    logic                              clk         = 1'b0;
    logic                              rst_n       = 1'b0;
    logic                              start       = 1'b0;
    logic                              busy;
    number_t                           number_in   = '0;
    logic                              strobe;
    logic [i2r_pkg::LETTER_W-1:0]      letter;
    logic                              last_letter;
    logic                              bad_value;
    logic                              cfg_valid   = 1'b0;
    logic                              cfg_ready;
    logic [i2r_pkg::CFG_IDX_W-1:0]     cfg_index   = '0;
    logic [i2r_pkg::CFG_DATA_W-1:0]    cfg_data    = '0;

    // Requests waiting to be sent and letters waiting to be seen
    number_t     send_q[$];
    letter_rec_t letters_due[$];
    letter_rec_t head_rec;

    // Register copies as the encoder should hold them
    logic        sub_mode   = 1'b0;
    logic        lower_mode = 1'b0;

    logic        req_taken    = 1'b0;
    int          idle_pct     = 18;
    int          err_count    = 0;
    int          quiet_cycles = 0;

    integer_to_roman_numeral #(
        .MAX_VALUE   (MAX_VALUE_TB)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .number_in   (number_in),
        .strobe      (strobe),
        .letter      (letter),
        .last_letter (last_letter),
        .bad_value   (bad_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Work out the letters one request should produce and queue them
    function automatic void predict_numeral(input number_t value);
        string       numeral;
        string       ones;
        string       fives;
        string       tens;
        int unsigned n;
        int unsigned d;
        int unsigned w;
        letter_rec_t rec;
        ones  = "CXI";
        fives = "DLV";
        tens  = "MCX";
        n     = value;
        if (n == 0 || n > MAX_VALUE_TB)
        begin
            rec.code = '0;
            rec.last = 1'b1;
            rec.bad  = 1'b1;
            letters_due.push_back(rec);
            return;
        end
        numeral = "";
        // Thousands are always repeated M, even past three
        repeat (n / 1000) numeral = {numeral, "M"};
        w = 100;
        for (int g = 0; g < 3; g++)
        begin
            d = (n / w) % 10;
            if (sub_mode && d == 9)
                numeral = {numeral, ones.substr(g, g), tens.substr(g, g)};
            else if (sub_mode && d == 4)
                numeral = {numeral, ones.substr(g, g), fives.substr(g, g)};
            else
            begin
                if (d >= 5)
                begin
                    numeral = {numeral, fives.substr(g, g)};
                    d = d - 5;
                end
                repeat (d) numeral = {numeral, ones.substr(g, g)};
            end
            w = w / 10;
        end
        for (int k = 0; k < numeral.len(); k++)
        begin
            rec.code = numeral[k] + (lower_mode ? 8'h20 : 8'h00);
            rec.last = (k == numeral.len() - 1);
            rec.bad  = 1'b0;
            letters_due.push_back(rec);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    // Driver: offer the next request, hold it until taken, idle at random
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || req_taken)
        begin
            if (send_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                start     <= 1'b1;
                number_in <= send_q.pop_front();
            end
            else
            begin
                start     <= 1'b0;
                number_in <= number_t'($urandom);
            end
        end
    end

    // Monitor: record requests and register writes, check letters, watch for hangs
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= start && !busy;
            if (start && !busy)
                predict_numeral(number_in);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == i2r_pkg::REG_SUBTRACTIVE)
                    sub_mode = cfg_data[0];
                else if (cfg_index == i2r_pkg::REG_LOWER_CASE)
                    lower_mode = cfg_data[0];
            end
            if (strobe)
            begin
                if (letters_due.size() == 0)
                    report_mismatch($sformatf("letter %02h last %b bad %b with nothing due",
                                              letter, last_letter, bad_value));
                else
                begin
                    head_rec = letters_due.pop_front();
                    if (head_rec.code !== letter || head_rec.last !== last_letter ||
                        head_rec.bad !== bad_value)
                        report_mismatch($sformatf(
                            "expected letter %02h last %b bad %b, got %02h %b %b",
                            head_rec.code, head_rec.last, head_rec.bad,
                            letter, last_letter, bad_value));
                end
            end
            if ((start && !busy) || strobe || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // Write one register and hold until the port takes it
    task automatic write_reg(input logic [i2r_pkg::CFG_IDX_W-1:0] idx, input logic value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= {7'($urandom), value};
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_index <= idx + 1'b1;
        cfg_data  <= 8'($urandom);
    endtask

    // Hold off until every request is sent and every letter has come back
    task automatic wait_idle();
        do @(posedge clk); while (send_q.size() != 0 || start || letters_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Stimulus sequence
    initial
    begin
        number_t     additive_cases[13];
        number_t     short_cases[11];
        int unsigned pick;
        int unsigned val;
        additive_cases = '{1, 4, 5, 9, 3888, 4999, 5000, 4000, 0, 5001, 8191, 4096, 2730};
        short_cases    = '{4, 9, 14, 40, 90, 400, 900, 1994, 3999, 4999, 944};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset form: additive, upper case
        foreach (additive_cases[i]) send_q.push_back(additive_cases[i]);
        wait_idle();

        // Subtractive pairs in upper case
        write_reg(i2r_pkg::REG_SUBTRACTIVE, 1'b1);
        foreach (short_cases[i]) send_q.push_back(short_cases[i]);
        wait_idle();

        // Random blocks, each under its own register setting and idle rate
        for (int blk = 0; blk < 4; blk++)
        begin
            case (blk)
                0:
                begin
                    write_reg(i2r_pkg::REG_LOWER_CASE, 1'b1);
                    idle_pct = 18;
                end
                1:
                begin
                    write_reg(i2r_pkg::REG_SUBTRACTIVE, 1'b0);
                    idle_pct = 60;
                end
                2:
                begin
                    // Writes past the two registers must change nothing
                    write_reg(REG_SPARE_A, 1'b1);
                    write_reg(REG_SPARE_B, 1'b1);
                    write_reg(i2r_pkg::REG_LOWER_CASE, 1'b0);
                    write_reg(i2r_pkg::REG_SUBTRACTIVE, 1'b1);
                    idle_pct = 0;
                end
                default:
                begin
                    write_reg(i2r_pkg::REG_SUBTRACTIVE, 1'b0);
                    idle_pct = 0;
                end
            endcase
            repeat (RANDOM_BLOCK)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    val = 0;
                else if (pick < 10)
                    val = $urandom_range(MAX_VALUE_TB + 1, TOP_INPUT);
                else if (pick < 25)
                    val = $urandom_range(1, 99);
                else
                    val = $urandom_range(1, MAX_VALUE_TB);
                send_q.push_back(number_t'(val));
            end
            wait_idle();
        end

        if (err_count == 0 && letters_due.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
